// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL of the quad float adder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication with a fixed delay in cycles, disabled while reset is asserted.
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("delayed check failed");

`endif

// File: rtl/core/qfas_pkg.sv
// ----------------------------------------------------------------------------
// qfas_pkg
// Types, constants and helpers for the binary128 magnitude adder.
// ----------------------------------------------------------------------------
`default_nettype none
package qfas_pkg;

  // Significand width with hidden bit, exponent widths.
  localparam int MANT_W  = 113;
  localparam int EXP_W   = 15;
  localparam int EXPX_W  = 16;
  localparam int SHIFT_W = 7;
  localparam logic [EXP_W-1:0] SHIFT_MAX = 15'd120;
  localparam logic [EXPX_W-1:0] EXP_OVF = 16'h7fff;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RMODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UFEN  = 1'd1;

  // Rounding modes.
  localparam logic [1:0] RM_NEAR = 2'd0;
  localparam logic [1:0] RM_ZERO = 2'd1;
  localparam logic [1:0] RM_UP   = 2'd2;
  localparam logic [1:0] RM_DOWN = 2'd3;

  // How the round stage treats a word.
  localparam logic [1:0] KIND_ROUND = 2'd0;
  localparam logic [1:0] KIND_EXACT = 2'd1;
  localparam logic [1:0] KIND_ZERO  = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic        result_sign;
    logic [63:0] x_upper;
    logic [63:0] x_lower;
    logic [63:0] y_upper;
    logic [63:0] y_lower;
  } in_word_t;

  typedef struct packed {
    logic [63:0] sum_upper;
    logic [63:0] sum_lower;
    logic        inexact_flag;
    logic        overflow_flag;
    logic        underflow_flag;
  } out_word_t;

  // Normalized word handed to the round stage.
  typedef struct packed {
    logic              sign;
    logic              is_add;
    logic [1:0]        kind;
    logic [MANT_W-1:0] mant;
    logic [EXPX_W-1:0] ex;
    logic              rnd;
    logic              stk;
  } rnd_in_t;

  // Leading zeros of a significand, counted from the hidden bit.
  function automatic logic [SHIFT_W-1:0] lzc_mant(input logic [MANT_W-1:0] v);
    logic [SHIFT_W-1:0] c;
    c = SHIFT_W'(MANT_W);
    for (int i = 0; i < MANT_W; i++) begin
      if (v[i]) c = SHIFT_W'(MANT_W - 1 - i);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/quad_float_magnitude_add_sub.sv
// An accepted word moves through the stage registers in order and out_valid is registered.
// Throughput: one word per cycle; the six-stage pipeline never stalls and busy stays low.
// Stages: unpack, align, add/subtract, leading-zero count, normalize shift, round.
// Reset clears the stage valid bits, rounding mode and underflow trap enable.
// ----------------------------------------------------------------------------
// quad_float_magnitude_add_sub
// Pipelined binary128 magnitude adder/subtractor with four rounding modes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module quad_float_magnitude_add_sub (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire qfas_pkg::in_word_t                in_word,
  output logic                                   out_valid,
  output qfas_pkg::out_word_t                    out_word,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [qfas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [qfas_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qfas_pkg::*;

  logic [1:0] rmode_r;
  logic       uf_en_r;

  // Stage 1 signals.
  logic [126:0]       xmag, ymag, amag, bmag;
  logic [EXP_W-1:0]   ea, eb, ea_e, eb_e, ediff;
  logic               v1_r, sub1_r, sign1_r;
  logic [MANT_W-1:0]  xm1_r, ym1_r;
  logic [EXP_W-1:0]   ex1_r;
  logic [SHIFT_W-1:0] n1_r;

  // Stage 2 signals.
  logic [MANT_W+1:0]  wext, wsh, wmask;
  logic               v2_r, sub2_r, sign2_r, g2_r, r2_r, s2_r;
  logic [MANT_W-1:0]  xm2_r, ya2_r;
  logic [EXP_W-1:0]   ex2_r;

  // Stage 3 signals.
  logic [MANT_W:0]    sum3;
  logic [MANT_W-1:0]  diff3;
  logic               borrow3;
  logic               v3_r, sub3_r, sign3_r, g3_r, r3_r, s3_r;
  logic [MANT_W:0]    m3_r;
  logic [EXP_W-1:0]   ex3_r;

  // Stage 4 signals.
  logic [SHIFT_W-1:0] lz4;
  logic [EXP_W-1:0]   exm1;
  logic               v4_r, sign4_r, add4_r, gin4_r, rnd4_r, stk4_r, onesh4_r;
  logic [1:0]         kind4_r;
  logic [MANT_W-1:0]  m4_r;
  logic [EXPX_W-1:0]  ex4_r;
  logic [SHIFT_W-1:0] k4_r;
  logic               rnd4_nxt, stk4_nxt, onesh4_nxt;
  logic [1:0]         kind4_nxt;
  logic [MANT_W-1:0]  m4_nxt;
  logic [EXPX_W-1:0]  ex4_nxt;
  logic [SHIFT_W-1:0] k4_nxt;

  // Stage 5 signals.
  logic [MANT_W:0]    lsh5;
  rnd_in_t            s5_nxt, s5_r;
  logic               v5_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmode_r <= RM_NEAR;
      uf_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RMODE: rmode_r <= cfg_data;
        CFG_UFEN:  uf_en_r <= cfg_data[0];
        default:   rmode_r <= rmode_r;
      endcase
    end
  end

  // Stage 1: order the magnitudes and find the alignment distance.
  always_comb begin
    xmag  = {in_word.x_upper[62:0], in_word.x_lower};
    ymag  = {in_word.y_upper[62:0], in_word.y_lower};
    amag  = (xmag < ymag) ? ymag : xmag;
    bmag  = (xmag < ymag) ? xmag : ymag;
    ea    = amag[126:112];
    eb    = bmag[126:112];
    ea_e  = (ea == '0) ? 15'd1 : ea;
    eb_e  = (eb == '0) ? 15'd1 : eb;
    ediff = ea_e - eb_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    sub1_r  <= in_word.req_type;
    sign1_r <= in_word.result_sign;
    xm1_r   <= {ea != '0, amag[111:0]};
    ym1_r   <= {eb != '0, bmag[111:0]};
    ex1_r   <= ea_e;
    n1_r    <= (ediff > SHIFT_MAX) ? SHIFT_MAX[SHIFT_W-1:0] : ediff[SHIFT_W-1:0];
  end

  // Stage 2: shift y right, keeping guard, round and sticky.
  always_comb begin
    wext  = {ym1_r, 2'b00};
    wsh   = wext >> n1_r;
    wmask = ~({(MANT_W+2){1'b1}} << n1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    sub2_r  <= sub1_r;
    sign2_r <= sign1_r;
    xm2_r   <= xm1_r;
    ex2_r   <= ex1_r;
    ya2_r   <= wsh[MANT_W+1:2];
    g2_r    <= wsh[1];
    r2_r    <= wsh[0];
    s2_r    <= |(wext & wmask);
  end

  // Stage 3: add or subtract the significands.
  always_comb begin
    borrow3 = g2_r | r2_r | s2_r;
    sum3    = {1'b0, xm2_r} + {1'b0, ya2_r};
    diff3   = xm2_r - ya2_r - {{(MANT_W-1){1'b0}}, borrow3};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    sub3_r  <= sub2_r;
    sign3_r <= sign2_r;
    ex3_r   <= ex2_r;
    m3_r    <= sub2_r ? {1'b0, diff3} : sum3;
    // The subtraction complements the shifted-out bits.
    g3_r    <= sub2_r ? (g2_r ^ (r2_r | s2_r)) : g2_r;
    r3_r    <= sub2_r ? (r2_r ^ s2_r) : r2_r;
    s3_r    <= s2_r;
  end

  // Stage 4: carry normalization for add, leading-zero count for subtract.
  always_comb begin
    lz4        = lzc_mant(m3_r[MANT_W-1:0]);
    exm1       = ex3_r - 15'd1;
    m4_nxt     = m3_r[MANT_W-1:0];
    ex4_nxt    = {1'b0, ex3_r};
    rnd4_nxt   = g3_r;
    stk4_nxt   = r3_r | s3_r;
    onesh4_nxt = 1'b0;
    kind4_nxt  = KIND_ROUND;
    k4_nxt     = '0;
    if (!sub3_r) begin
      if (m3_r[MANT_W]) begin
        m4_nxt   = m3_r[MANT_W:1];
        ex4_nxt  = {1'b0, ex3_r} + 16'd1;
        rnd4_nxt = m3_r[0];
        stk4_nxt = g3_r | r3_r | s3_r;
      end
    end else if (m3_r[MANT_W-1:0] == '0 && !g3_r) begin
      kind4_nxt = KIND_ZERO;
    end else if (!m3_r[MANT_W-1] && (!m3_r[MANT_W-2] || ex3_r == 15'd1)) begin
      kind4_nxt = KIND_EXACT;
      k4_nxt    = ({8'd0, lz4} < exm1) ? lz4 : exm1[SHIFT_W-1:0];
    end else if (!m3_r[MANT_W-1]) begin
      onesh4_nxt = 1'b1;
      rnd4_nxt   = r3_r;
      stk4_nxt   = s3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    sign4_r  <= sign3_r;
    add4_r   <= !sub3_r;
    gin4_r   <= g3_r;
    m4_r     <= m4_nxt;
    ex4_r    <= ex4_nxt;
    rnd4_r   <= rnd4_nxt;
    stk4_r   <= stk4_nxt;
    onesh4_r <= onesh4_nxt;
    kind4_r  <= kind4_nxt;
    k4_r     <= k4_nxt;
  end

  // Stage 5: left shift of a cancelled difference, guard bit first.
  always_comb begin
    lsh5          = {m4_r, gin4_r} << k4_r;
    s5_nxt.sign   = sign4_r;
    s5_nxt.is_add = add4_r;
    s5_nxt.kind   = kind4_r;
    s5_nxt.mant   = m4_r;
    s5_nxt.ex     = ex4_r;
    s5_nxt.rnd    = rnd4_r;
    s5_nxt.stk    = stk4_r;
    if (kind4_r == KIND_EXACT) begin
      s5_nxt.mant = lsh5[MANT_W:1];
      s5_nxt.ex   = ex4_r - {9'd0, k4_r};
    end else if (onesh4_r) begin
      s5_nxt.mant = {m4_r[MANT_W-2:0], gin4_r};
      s5_nxt.ex   = ex4_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    s5_r <= s5_nxt;
  end

  // Stage 6: rounding and packing.
  qfas_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_stage  (s5_r),
    .rmode     (rmode_r),
    .uf_en     (uf_en_r),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // Every started word comes out after the full pipeline depth.
  `ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, 6, out_valid)
  // Overflow always reports inexact as well.
  `ASSERT_IMPLY(a_ovf_inexact, clk, rst_n, out_valid && out_word.overflow_flag, out_word.inexact_flag)
  // A tiny result can never overflow.
  `ASSERT_IMPLY(a_uf_not_ovf, clk, rst_n, out_valid && out_word.underflow_flag, !out_word.overflow_flag)

endmodule
`default_nettype wire

// File: rtl/core/qfas_round.sv
// ----------------------------------------------------------------------------
// qfas_round
// Final stage: rounding increment, overflow handling and result packing.
// ----------------------------------------------------------------------------
`default_nettype none
module qfas_round (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire qfas_pkg::rnd_in_t in_stage,
  input  wire logic [1:0]        rmode,
  input  wire logic              uf_en,
  output logic                   out_valid,
  output qfas_pkg::out_word_t    out_word
);
  import qfas_pkg::*;

  logic [1:0]        rm;
  logic              inx;
  logic              inc;
  logic [MANT_W:0]   mi;
  logic [MANT_W-1:0] mr;
  logic [EXPX_W-1:0] exr;
  logic [EXP_W-1:0]  exf;
  out_word_t         res;
  logic              out_valid_r;
  out_word_t         out_word_r;

  // Directed modes swap for a negative result.
  assign rm  = in_stage.sign ? (rmode ^ {1'b0, rmode[1]}) : rmode;
  assign inx = in_stage.rnd | in_stage.stk;
  assign inc = inx && (rm == RM_UP ||
               (rm == RM_NEAR && in_stage.rnd && (in_stage.stk || in_stage.mant[0])));

  // Increment and renormalize on carry out.
  always_comb begin
    mi = {1'b0, in_stage.mant} + {{MANT_W{1'b0}}, inc};
    if (mi[MANT_W]) begin
      mr  = mi[MANT_W:1];
      exr = in_stage.ex + 16'd1;
    end else begin
      mr  = mi[MANT_W-1:0];
      exr = in_stage.ex;
    end
  end

  // Pack the result word.
  always_comb begin
    res = '0;
    exf = mr[MANT_W-1] ? exr[EXP_W-1:0] : '0;
    case (in_stage.kind)
      KIND_ZERO: begin
        res.sum_upper = (rmode == RM_DOWN) ? {1'b1, 63'd0} : 64'd0;
      end
      KIND_EXACT: begin
        res.sum_upper = {in_stage.sign,
                         in_stage.mant[MANT_W-1] ? in_stage.ex[EXP_W-1:0] : 15'd0,
                         in_stage.mant[111:64]};
        res.sum_lower = in_stage.mant[63:0];
        res.underflow_flag = !in_stage.mant[MANT_W-1] && uf_en;
      end
      KIND_ROUND: begin
        res.inexact_flag = inx;
        if (!in_stage.is_add) begin
          res.sum_upper = {in_stage.sign, exr[EXP_W-1:0], mr[111:64]};
          res.sum_lower = mr[63:0];
        end else if (exr >= EXP_OVF) begin
          res.inexact_flag  = 1'b1;
          res.overflow_flag = 1'b1;
          if (rm == RM_NEAR || rm == RM_UP) begin
            res.sum_upper = {in_stage.sign, 15'h7fff, 48'd0};
            res.sum_lower = 64'd0;
          end else begin
            res.sum_upper = {in_stage.sign, 15'h7ffe, {48{1'b1}}};
            res.sum_lower = {64{1'b1}};
          end
        end else begin
          res.sum_upper = {in_stage.sign, exf, mr[111:64]};
          res.sum_lower = mr[63:0];
          res.underflow_flag = !in_stage.mant[MANT_W-1] && uf_en;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
    out_word_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire
